### design/cfhp_pkg.sv
// ----------------------------------------------------------------------------
// cfhp_pkg
// Shared types, constants and the byte-wide CRC-32 update of the frame header
// parser.
// ----------------------------------------------------------------------------
package cfhp_pkg;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam int unsigned HdrBytes = 16;
  localparam int unsigned HdrIdxW  = $clog2(HdrBytes);

  localparam logic [HdrIdxW-1:0] MagicEnd = HdrIdxW'(4);
  localparam logic [HdrIdxW-1:0] FieldEnd = HdrIdxW'(12);
  localparam logic [HdrIdxW-1:0] CrcEnd   = HdrIdxW'(HdrBytes - 1);

  localparam logic KindStatus  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_CRC     = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TOO_LARGE   = 3'd4,
    ST_BAD_TYPE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_MAGIC       = 2'd0,
    REG_VERSION     = 2'd1,
    REG_MAX_PAYLOAD = 2'd2,
    REG_TYPE_MASK   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [15:0] protocol_version;
    logic [31:0] max_payload;
    logic [63:0] known_type_mask;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    status_e     status;
    logic [15:0] message_type;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/cfhp_if.sv
// ----------------------------------------------------------------------------
// cfhp_if
// Valid/ready channels of the frame header parser: byte stream in, results out.
// ----------------------------------------------------------------------------
interface cfhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface cfhp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [15:0] message_type;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (
    output valid, output kind, output status, output message_type,
    output payload_length, output payload_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input status, input message_type,
    input payload_length, input payload_byte, input last, output ready
  );
endinterface

### design/cfhp_cfg.sv
// ----------------------------------------------------------------------------
// cfhp_cfg
// Configuration registers: magic, version, maximum payload, known-type mask.
// ----------------------------------------------------------------------------
module cfhp_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output cfhp_pkg::cfg_t      cfg_o
);

  cfhp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfhp_pkg::reg_idx_e'(cfg_index_i))
        cfhp_pkg::REG_MAGIC:       cfg_d.frame_magic      = cfg_data_i[31:0];
        cfhp_pkg::REG_VERSION:     cfg_d.protocol_version = cfg_data_i[15:0];
        cfhp_pkg::REG_MAX_PAYLOAD: cfg_d.max_payload      = cfg_data_i[31:0];
        cfhp_pkg::REG_TYPE_MASK:   cfg_d.known_type_mask  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_magic      <= 32'd0;
      cfg_q.protocol_version <= 16'd1;
      cfg_q.max_payload      <= 32'd65536;
      cfg_q.known_type_mask  <= 64'd1022;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/cfhp_parser.sv
// ----------------------------------------------------------------------------
// cfhp_parser
// Header gathering, CRC-32 update, header checks and payload pass-through for
// one byte per step.
// ----------------------------------------------------------------------------
module cfhp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  cfhp_pkg::cfg_t       cfg_i,
  output logic                 res_valid_o,
  output cfhp_pkg::result_t    res_o
);

  logic                           in_payload_q, in_payload_d;
  logic [cfhp_pkg::HdrIdxW-1:0]   hdr_idx_q, hdr_idx_d;
  logic [31:0]                    crc_q, crc_d;
  logic                           magic_ok_q, magic_ok_d;
  logic [31:0]                    remaining_q, remaining_d;
  logic [63:0]                    hdr_fields_q, hdr_fields_d;
  logic [23:0]                    crc_field_q, crc_field_d;

  logic [31:0] crc_upd;
  logic [31:0] rem_dec;
  logic [31:0] rx_crc;
  logic [15:0] version;
  logic [15:0] mtype;
  logic [31:0] plen;
  logic [2:0]  field_off;
  logic [1:0]  crc_off;
  logic [1:0]  magic_off;
  cfhp_pkg::status_e status;

  assign crc_upd   = cfhp_pkg::crc_byte(crc_q, data_byte_i);
  assign rem_dec   = (remaining_q != 32'd0) ? remaining_q - 32'd1 : remaining_q;
  assign version   = hdr_fields_q[15:0];
  assign mtype     = hdr_fields_q[31:16];
  assign plen      = hdr_fields_q[63:32];
  assign rx_crc    = {data_byte_i, crc_field_q};
  assign magic_off = hdr_idx_q[1:0];
  assign field_off = 3'(hdr_idx_q - cfhp_pkg::MagicEnd);
  assign crc_off   = 2'(hdr_idx_q - cfhp_pkg::FieldEnd);

  always_comb begin
    if (!magic_ok_q) begin
      status = cfhp_pkg::ST_BAD_MAGIC;
    end else if (rx_crc != (crc_q ^ cfhp_pkg::CrcInit)) begin
      status = cfhp_pkg::ST_BAD_CRC;
    end else if (version != cfg_i.protocol_version) begin
      status = cfhp_pkg::ST_BAD_VERSION;
    end else if (plen > cfg_i.max_payload) begin
      status = cfhp_pkg::ST_TOO_LARGE;
    end else if (mtype[15:6] != 10'd0 || !cfg_i.known_type_mask[mtype[5:0]]) begin
      status = cfhp_pkg::ST_BAD_TYPE;
    end else begin
      status = cfhp_pkg::ST_OK;
    end
  end

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_idx_d    = hdr_idx_q;
    crc_d        = crc_q;
    magic_ok_d   = magic_ok_q;
    remaining_d  = remaining_q;
    hdr_fields_d = hdr_fields_q;
    crc_field_d  = crc_field_q;

    res_valid_o          = 1'b0;
    res_o.kind           = cfhp_pkg::KindStatus;
    res_o.status         = cfhp_pkg::ST_OK;
    res_o.message_type   = mtype;
    res_o.payload_length = plen;
    res_o.payload_byte   = 8'd0;
    res_o.last           = 1'b0;

    if (step_i) begin
      if (in_payload_q) begin
        res_valid_o        = 1'b1;
        res_o.kind         = cfhp_pkg::KindPayload;
        res_o.payload_byte = data_byte_i;
        res_o.last         = (rem_dec == 32'd0);
        remaining_d        = rem_dec;
        if (rem_dec == 32'd0) begin
          in_payload_d = 1'b0;
          hdr_idx_d    = '0;
          crc_d        = cfhp_pkg::CrcInit;
          magic_ok_d   = 1'b1;
        end
      end else begin
        if (hdr_idx_q < cfhp_pkg::FieldEnd) begin
          crc_d = crc_upd;
        end
        if (hdr_idx_q < cfhp_pkg::MagicEnd) begin
          if (cfg_i.frame_magic[{magic_off, 3'b000} +: 8] != data_byte_i) begin
            magic_ok_d = 1'b0;
          end
        end else if (hdr_idx_q < cfhp_pkg::FieldEnd) begin
          hdr_fields_d[{field_off, 3'b000} +: 8] = data_byte_i;
        end else if (hdr_idx_q < cfhp_pkg::CrcEnd) begin
          crc_field_d[{crc_off, 3'b000} +: 8] = data_byte_i;
        end

        if (hdr_idx_q != cfhp_pkg::CrcEnd) begin
          hdr_idx_d = hdr_idx_q + cfhp_pkg::HdrIdxW'(1);
        end else begin
          res_valid_o  = 1'b1;
          res_o.status = status;
          res_o.last   = (status != cfhp_pkg::ST_OK) || (plen == 32'd0);
          hdr_idx_d    = '0;
          crc_d        = cfhp_pkg::CrcInit;
          magic_ok_d   = 1'b1;
          if (status == cfhp_pkg::ST_OK && plen != 32'd0) begin
            in_payload_d = 1'b1;
            remaining_d  = plen;
          end else begin
            in_payload_d = 1'b0;
            remaining_d  = 32'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_idx_q    <= '0;
      crc_q        <= cfhp_pkg::CrcInit;
      magic_ok_q   <= 1'b1;
      remaining_q  <= 32'd0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_idx_q    <= hdr_idx_d;
      crc_q        <= crc_d;
      magic_ok_q   <= magic_ok_d;
      remaining_q  <= remaining_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_fields_q <= hdr_fields_d;
    crc_field_q  <= crc_field_d;
  end

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> remaining_q != 32'd0)
    else $error("payload phase with no bytes left");

  a_payload_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> hdr_idx_q == '0)
    else $error("header index moved during payload");

  a_header_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !in_payload_q && hdr_idx_q != cfhp_pkg::CrcEnd |-> !res_valid_o)
    else $error("result before the last header byte");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.last |=> !in_payload_q && hdr_idx_q == '0
      && crc_q == cfhp_pkg::CrcInit)
    else $error("frame end did not restart header gathering");

endmodule

### design/crc_checked_frame_header_parser_unit.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_header_parser_unit
// Stream parser for length-prefixed frames with a CRC-32 checked header.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back, while the output is not stalled: a
// byte goes into an input register, is parsed once the output register can
// take a result, and that result, if any, is registered there. The byte-wide
// CRC-32 update and the header compare chain between the input and output
// registers set the clock limit. Header bytes 1 to 15 give no result, the 16th
// gives one status, and each payload byte gives one result. A stalled output
// holds the pipeline; configuration takes effect on the next byte.
// ----------------------------------------------------------------------------
module crc_checked_frame_header_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  cfhp_byte_if.sink     byte_i,
  cfhp_result_if.source result_o
);

  cfhp_pkg::cfg_t    cfg;
  cfhp_pkg::result_t res;
  logic              res_valid;

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  cfhp_pkg::result_t out_q;
  logic              slot_free;
  logic              step;
  logic              in_take;

  assign slot_free    = !out_valid_q || result_o.ready;
  assign step         = in_valid_q && slot_free;
  assign byte_i.ready = !in_valid_q || slot_free;
  assign in_take      = byte_i.valid && byte_i.ready;

  cfhp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cfhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (slot_free) begin
      out_valid_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.data_byte;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.kind           = out_q.kind;
  assign result_o.status         = out_q.status;
  assign result_o.message_type   = out_q.message_type;
  assign result_o.payload_length = out_q.payload_length;
  assign result_o.payload_byte   = out_q.payload_byte;
  assign result_o.last           = out_q.last;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CRC-checked frame header parser. A byte queue
// feeds a bursty valid/ready driver. Every accepted byte runs through an
// in-bench parser model that predicts the status and payload results. A
// stalling monitor compares each result field by field. Directed frames hit
// every status, the check order, empty payloads and a register write that
// lands mid-header. Random phases then mix mostly good frames with noise and
// broken headers under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int QuietLimit   = 4000;
  localparam int SettleCycles = 4;
  localparam int PhaseBytes   = 90;

  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_CRC,
    FAULT_VERSION,
    FAULT_LENGTH,
    FAULT_TYPE,
    FAULT_NOISE
  } fault_e;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  cfhp_byte_if   byte_if ();
  cfhp_result_if result_if ();

  crc_checked_frame_header_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_i      (byte_if),
    .result_o    (result_if)
  );

  cfhp_pkg::cfg_t parser_cfg;
  logic           in_payload;
  logic [3:0]     hdr_pos;
  logic [31:0]    hdr_crc;
  logic [63:0]    hdr_fields;
  logic [23:0]    rx_crc_low;
  logic [31:0]    payload_left;
  logic           magic_seen_ok;

  cfhp_pkg::result_t awaited_results[$];
  logic [7:0]        tx_bytes[$];
  cfhp_pkg::result_t got_result;
  cfhp_pkg::result_t want_result;

  int    burst_left;
  int    gap_left;
  sink_e sink_mode;
  int    sink_cycle;

  int bytes_sent;
  int status_seen;
  int ok_seen;
  int payload_seen;
  int mismatches;
  int settings_used;

  function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ cfhp_pkg::CrcPoly;
    end
    return c;
  endfunction

  function automatic void restart_header_hunt();
    in_payload    = 1'b0;
    hdr_pos       = '0;
    hdr_crc       = cfhp_pkg::CrcInit;
    magic_seen_ok = 1'b1;
  endfunction

  function automatic void parse_stream_byte(logic [7:0] b);
    cfhp_pkg::result_t r;
    int                pos;
    logic [31:0]       rx_crc;
    logic [15:0]       mtype;
    logic [31:0]       plen;
    cfhp_pkg::status_e st;
    pos   = hdr_pos;
    r     = '0;
    mtype = hdr_fields[31:16];
    plen  = hdr_fields[63:32];
    if (in_payload) begin
      if (payload_left != 0) payload_left = payload_left - 1;
      r.kind           = cfhp_pkg::KindPayload;
      r.status         = cfhp_pkg::ST_OK;
      r.message_type   = mtype;
      r.payload_length = plen;
      r.payload_byte   = b;
      r.last           = (payload_left == 0);
      if (payload_left == 0) restart_header_hunt();
      awaited_results.push_back(r);
      return;
    end
    if (pos < 12) hdr_crc = crc32_step(hdr_crc, b);
    if (pos < 4) begin
      if (parser_cfg.frame_magic[8*pos +: 8] != b) magic_seen_ok = 1'b0;
    end else if (pos < 12) begin
      hdr_fields[8*(pos-4) +: 8] = b;
    end else if (pos < 15) begin
      rx_crc_low[8*(pos-12) +: 8] = b;
    end
    if (pos < 15) begin
      hdr_pos = hdr_pos + 4'd1;
      return;
    end
    rx_crc = {b, rx_crc_low};
    if (!magic_seen_ok) st = cfhp_pkg::ST_BAD_MAGIC;
    else if (rx_crc != ~hdr_crc) st = cfhp_pkg::ST_BAD_CRC;
    else if (hdr_fields[15:0] != parser_cfg.protocol_version) st = cfhp_pkg::ST_BAD_VERSION;
    else if (plen > parser_cfg.max_payload) st = cfhp_pkg::ST_TOO_LARGE;
    else if (mtype >= 64 || !parser_cfg.known_type_mask[mtype[5:0]])
      st = cfhp_pkg::ST_BAD_TYPE;
    else st = cfhp_pkg::ST_OK;
    r.kind           = cfhp_pkg::KindStatus;
    r.status         = st;
    r.message_type   = mtype;
    r.payload_length = plen;
    r.payload_byte   = '0;
    r.last           = (st != cfhp_pkg::ST_OK) || (plen == 0);
    awaited_results.push_back(r);
    restart_header_hunt();
    if (st == cfhp_pkg::ST_OK && plen != 0) begin
      in_payload   = 1'b1;
      payload_left = plen;
    end else begin
      payload_left = '0;
    end
  endfunction

  function automatic logic [127:0] build_header(logic [31:0] magic, logic [15:0] version,
                                                logic [15:0] mtype, logic [31:0] plen,
                                                logic [31:0] crc_flip);
    logic [95:0] body;
    logic [31:0] c;
    body = {plen, mtype, version, magic};
    c    = cfhp_pkg::CrcInit;
    for (int i = 0; i < 12; i++) c = crc32_step(c, body[8*i +: 8]);
    return {~c ^ crc_flip, body};
  endfunction

  function automatic void push_header_bytes(logic [127:0] h, int lo, int hi);
    for (int i = lo; i <= hi; i++) tx_bytes.push_back(h[8*i +: 8]);
  endfunction

  function automatic void queue_frame(logic [31:0] magic, logic [15:0] version,
                                      logic [15:0] mtype, logic [31:0] plen,
                                      logic [31:0] crc_flip, int npay);
    push_header_bytes(build_header(magic, version, mtype, plen, crc_flip), 0, 15);
    repeat (npay) tx_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int find_type(logic want_known);
    int off;
    int t;
    off = $urandom_range(0, 63);
    for (int i = 0; i < 64; i++) begin
      t = (off + i) % 64;
      if (parser_cfg.known_type_mask[t] == want_known) return t;
    end
    return -1;
  endfunction

  function automatic void queue_random_frame();
    fault_e      fault;
    logic [31:0] magic;
    logic [31:0] plen;
    logic [31:0] flip;
    logic [15:0] version;
    logic [15:0] mtype;
    logic [7:0]  b0;
    int          lim;
    int          found;
    int          npay;
    magic   = parser_cfg.frame_magic;
    version = parser_cfg.protocol_version;
    flip    = '0;
    fault   = ($urandom_range(0, 2) != 0) ? FAULT_NONE :
              fault_e'($urandom_range(int'(FAULT_MAGIC), int'(FAULT_NOISE)));
    if (fault == FAULT_LENGTH && parser_cfg.max_payload == '1) fault = FAULT_VERSION;
    if (fault == FAULT_NOISE) begin
      b0 = 8'($urandom_range(0, 255));
      if (b0 == magic[7:0]) b0 = ~b0;
      tx_bytes.push_back(b0);
      repeat (15) tx_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    lim = ($urandom_range(0, 9) == 0) ? 60 : 8;
    if (parser_cfg.max_payload < lim) lim = parser_cfg.max_payload;
    plen  = $urandom_range(0, lim);
    found = find_type(1'b1);
    mtype = (found >= 0) ? 16'(found) : 16'($urandom_range(64, 65535));
    case (fault)
      FAULT_MAGIC: begin
        magic = magic ^ (32'd1 << $urandom_range(0, 31));
        plen  = $urandom();
      end
      FAULT_CRC: begin
        flip = 32'd1 << $urandom_range(0, 31);
        plen = $urandom();
      end
      FAULT_VERSION: begin
        version = version ^ 16'($urandom_range(1, 65535));
        plen    = $urandom();
      end
      FAULT_LENGTH: begin
        plen = $urandom_range(parser_cfg.max_payload + 32'd1, 32'hFFFF_FFFF);
      end
      FAULT_TYPE: begin
        found = ($urandom_range(0, 1) == 1) ? find_type(1'b0) : -1;
        mtype = (found >= 0) ? 16'(found) : 16'($urandom_range(64, 65535));
      end
      default: ;
    endcase
    npay = (fault == FAULT_NONE && found >= 0) ? int'(plen) : 0;
    queue_frame(magic, version, mtype, plen, flip, npay);
  endfunction

  function automatic string fmt_result(cfhp_pkg::result_t r);
    return $sformatf("kind %0d status %0d type %0h len %0h byte %0h last %0d",
                     r.kind, r.status, r.message_type, r.payload_length,
                     r.payload_byte, r.last);
  endfunction

  task automatic write_reg(input cfhp_pkg::reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cfhp_pkg::REG_MAGIC:       parser_cfg.frame_magic      = value[31:0];
      cfhp_pkg::REG_VERSION:     parser_cfg.protocol_version = value[15:0];
      cfhp_pkg::REG_MAX_PAYLOAD: parser_cfg.max_payload      = value[31:0];
      cfhp_pkg::REG_TYPE_MASK:   parser_cfg.known_type_mask  = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] magic, input logic [15:0] version,
                                input logic [31:0] max_len, input logic [63:0] mask);
    write_reg(cfhp_pkg::REG_MAGIC, {32'd0, magic});
    write_reg(cfhp_pkg::REG_VERSION, {48'd0, version});
    write_reg(cfhp_pkg::REG_MAX_PAYLOAD, {32'd0, max_len});
    write_reg(cfhp_pkg::REG_TYPE_MASK, mask);
    settings_used++;
  endtask

  task automatic settle();
    while (tx_bytes.size() != 0 || byte_if.valid || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= '0;
      burst_left        <= 0;
      gap_left          <= 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        parse_stream_byte(byte_if.data_byte);
        bytes_sent++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          byte_if.valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          byte_if.valid     <= 1'b1;
          byte_if.data_byte <= tx_bytes.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      sink_mode       <= SINK_OPEN;
      sink_cycle      <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_result.kind           = result_if.kind;
        got_result.status         = cfhp_pkg::status_e'(result_if.status);
        got_result.message_type   = result_if.message_type;
        got_result.payload_length = result_if.payload_length;
        got_result.payload_byte   = result_if.payload_byte;
        got_result.last           = result_if.last;
        if (awaited_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %s", fmt_result(got_result));
          mismatches++;
        end else begin
          want_result = awaited_results.pop_front();
          if (want_result.kind == cfhp_pkg::KindStatus) begin
            status_seen++;
            if (want_result.status == cfhp_pkg::ST_OK) ok_seen++;
          end else begin
            payload_seen++;
          end
          if (got_result.kind !== want_result.kind ||
              got_result.status !== want_result.status ||
              got_result.message_type !== want_result.message_type ||
              got_result.payload_length !== want_result.payload_length ||
              got_result.payload_byte !== want_result.payload_byte ||
              got_result.last !== want_result.last) begin
            if (mismatches < 10) begin
              $display("result mismatch: got %s", fmt_result(got_result));
              $display("                want %s", fmt_result(want_result));
            end
            mismatches++;
          end
        end
      end
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle % 128 == 127) sink_mode <= sink_e'($urandom_range(0, 3));
      case (sink_mode)
        SINK_OPEN:     result_if.ready <= 1'b1;
        SINK_RANDOM:   result_if.ready <= ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: result_if.ready <= (sink_cycle % 5) < 2;
        default:       result_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("crc_checked_frame_header_parser_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [127:0] split_hdr;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = cfhp_pkg::REG_MAGIC;
    cfg_data_i        = '0;
    bytes_sent        = 0;
    status_seen       = 0;
    ok_seen           = 0;
    payload_seen      = 0;
    mismatches        = 0;
    settings_used     = 1;
    parser_cfg        = '{frame_magic: 32'd0, protocol_version: 16'd1,
                          max_payload: 32'd65536, known_type_mask: 64'h3FE};
    hdr_fields        = '0;
    rx_crc_low        = '0;
    payload_left      = '0;
    restart_header_hunt();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    queue_frame(32'd0, 16'd1, 16'd1, 32'd2, 32'd0, 2);
    queue_frame(32'd0, 16'd1, 16'd9, 32'd0, 32'd0, 0);
    queue_frame(32'd0, 16'd1, 16'd0, 32'd5, 32'd0, 0);
    queue_frame(32'd0, 16'd1, 16'd3, 32'd65537, 32'd0, 0);
    queue_frame(32'h0000_0100, 16'd1, 16'd1, 32'd1, 32'h1, 0);
    queue_frame(32'd0, 16'd1, 16'd1, 32'd1, 32'h8000_0000, 0);
    queue_frame(32'd0, 16'd2, 16'd1, 32'd1, 32'h1, 0);
    queue_frame(32'd0, 16'd0, 16'd99, 32'd70000, 32'd0, 0);
    queue_frame(32'd0, 16'd1, 16'd0, 32'd70000, 32'd0, 0);
    // change the version between the two halves of a header
    split_hdr = build_header(32'd0, 16'd7, 16'd2, 32'd1, 32'd0);
    push_header_bytes(split_hdr, 0, 7);
    settle();
    write_reg(cfhp_pkg::REG_VERSION, 64'd7);
    settings_used++;
    push_header_bytes(split_hdr, 8, 15);
    tx_bytes.push_back(8'hC3);
    settle();

    apply_settings(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd63, 32'd0, 32'd0, 0);
    queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'd64, 32'd0, 32'd0, 0);
    queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd1, 32'd0, 0);
    settle();

    apply_settings(32'h5AA5_C33C, 16'd0, 32'hFFFF_FFFE, 64'h8000_0000_0000_0001);
    queue_frame(32'h5AA5_C33C, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 0);
    queue_frame(32'h5AA5_C33C, 16'd0, 16'd0, 32'd4, 32'd0, 0);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'hA5);
    tx_bytes.push_back(8'h5A);
    queue_frame(32'h5AA5_C33C, 16'd0, 16'd63, 32'd1, 32'd0, 1);
    queue_frame(32'h5AA5_C33C, 16'd0, 16'd62, 32'd0, 32'd0, 0);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_settings($urandom(), 16'($urandom_range(0, 65535)), 32'hFFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF);
        1: apply_settings($urandom(), 16'd0, $urandom_range(1, 20), {$urandom(), $urandom()});
        2: apply_settings(32'd0, 16'hFFFF, 32'd65536, 64'd0);
        3: apply_settings($urandom(), 16'($urandom_range(0, 65535)), $urandom(),
                          {$urandom(), $urandom()});
        default: apply_settings(32'hFFFF_FFFF, 16'd1, 32'd0, 64'h3FE);
      endcase
      while (tx_bytes.size() < PhaseBytes) queue_random_frame();
      settle();
    end

    repeat (8) @(posedge clk_i);
    $display("stream of %0d bytes under %0d register settings", bytes_sent, settings_used);
    $display("checked %0d header results (%0d ok) and %0d payload bytes, %0d mismatches",
             status_seen, ok_seen, payload_seen, mismatches);
    if (mismatches == 0) begin
      $display("crc_checked_frame_header_parser_unit: match");
    end else begin
      $display("crc_checked_frame_header_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

### crc_checked_frame_header_parser_unit.f
design/cfhp_pkg.sv
design/cfhp_if.sv
design/cfhp_cfg.sv
design/cfhp_parser.sv
design/crc_checked_frame_header_parser_unit.sv
test/testbench.sv
